@@ rtl/core/rtbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbe_pkg - shared types and constants of the timing budget encoder
// Transfer structs, status codes and datapath widths used by the core.
// ----------------------------------------------------------------------------
package rtbe_pkg;

   // transfer payloads
   typedef struct packed {
      logic [7:0]  timing_budget_ms;
      logic [15:0] inter_measurement_ms;
      logic [15:0] osc_frequency;
      logic [9:0]  clock_pll;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] cfg_word_a;
      logic [15:0] cfg_word_b;
      logic [31:0] intermeasurement_value;
   } rsp_type;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BUDGET  = 3'd1;
   localparam logic [2:0] ST_OSC     = 3'd2;
   localparam logic [2:0] ST_PERIOD  = 3'd3;
   localparam logic [2:0] ST_DIVZERO = 3'd4;

   // budget limits and mode offsets
   localparam int unsigned BUDGET_MIN_MS  = 10;
   localparam int unsigned BUDGET_MAX_MS  = 200;
   localparam int unsigned US_PER_MS      = 1000;
   localparam int unsigned CONT_OFFSET_US = 2500;
   localparam int unsigned AUTO_OFFSET_US = 4300;
   localparam int unsigned BUS_W          = 18;   // budget in us

   // 1.055 scaling as 211 / 200
   localparam int unsigned IMV_NUMER = 211;
   localparam int unsigned IMV_DENOM = 200;

   // shared divider
   localparam int unsigned DIVIDEND_W  = 34;
   localparam int unsigned DIVISOR_W   = 24;
   localparam int unsigned DIV_CNT_W   = 6;
   localparam int unsigned WORD_NUM_W  = 31;      // 2^30 and the scaled budgets
   localparam int unsigned WORD_ALIGN  = DIVIDEND_W - WORD_NUM_W;

   // serial multiplier: (period * 211) x pll
   localparam int unsigned MCAND_W  = 24;
   localparam int unsigned MPLIER_W = 10;

   // exponent:mantissa normaliser
   localparam int unsigned NORM_IN_W = 32;
   localparam int unsigned MANT_W    = 8;
   localparam int unsigned EXP_W     = 5;

endpackage

@@ rtl/core/rtbe_serial_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbe_serial_div - restoring divider, one quotient bit per cycle
// Dividend is loaded left aligned; after the given number of steps the
// quotient sits in the low bits of the shift register.
// ----------------------------------------------------------------------------
module rtbe_serial_div #(
   parameter int unsigned DIVIDEND_W = rtbe_pkg::DIVIDEND_W,
   parameter int unsigned DIVISOR_W  = rtbe_pkg::DIVISOR_W,
   parameter int unsigned CNT_W      = rtbe_pkg::DIV_CNT_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   input  logic [CNT_W-1:0]      iterations,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff     = shifted - {1'b0, divisor_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = iterations;
      end else if (busy) begin
         // no borrow: the shifted remainder covers the divisor
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

endmodule

@@ rtl/core/rtbe_serial_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbe_serial_mul - shift-and-add multiplier, one multiplier bit per cycle
// Produces the full-width unsigned product.
// ----------------------------------------------------------------------------
module rtbe_serial_mul #(
   parameter int unsigned MCAND_W  = rtbe_pkg::MCAND_W,
   parameter int unsigned MPLIER_W = rtbe_pkg::MPLIER_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [MCAND_W-1:0]            multiplicand,
   input  logic [MPLIER_W-1:0]           multiplier,
   output logic                          busy,
   output logic [MCAND_W+MPLIER_W-1:0]   product
);

   localparam int unsigned PROD_W = MCAND_W + MPLIER_W;
   localparam int unsigned CNT_W  = $clog2(MPLIER_W + 1);

   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [MPLIER_W-1:0] mplier_ff, mplier_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign busy    = (count_ff != '0);
   assign product = acc_ff;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      if (start) begin
         acc_in    = '0;
         mcand_in  = PROD_W'(multiplicand);
         mplier_in = multiplier;
         count_in  = CNT_W'(MPLIER_W);
      end else if (busy) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MPLIER_W-1:1]};
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

endmodule

@@ rtl/core/rtbe_normalise.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbe_normalise - exponent:mantissa normaliser
// Shifts the value right one bit per cycle until it fits the mantissa,
// counting the shifts as the exponent.
// ----------------------------------------------------------------------------
module rtbe_normalise #(
   parameter int unsigned IN_W   = rtbe_pkg::NORM_IN_W,
   parameter int unsigned MANT_W = rtbe_pkg::MANT_W,
   parameter int unsigned EXP_W  = rtbe_pkg::EXP_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IN_W-1:0]   value,
   output logic              busy,
   output logic [EXP_W-1:0]  exponent,
   output logic [MANT_W-1:0] mantissa
);

   logic [IN_W-1:0]  value_ff, value_in;
   logic [EXP_W-1:0] exp_ff, exp_in;
   logic             busy_ff, busy_in;
   logic             too_wide;

   assign too_wide = (value_ff[IN_W-1:MANT_W] != '0);
   assign busy     = busy_ff;
   assign exponent = exp_ff;
   assign mantissa = value_ff[MANT_W-1:0];

   always_comb begin
      value_in = value_ff;
      exp_in   = exp_ff;
      busy_in  = busy_ff;
      if (start) begin
         value_in = value;
         exp_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (too_wide) begin
            value_in = {1'b0, value_ff[IN_W-1:1]};
            exp_in   = exp_ff + 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      exp_ff   <= exp_in;
   end

endmodule

@@ rtl/core/ranging_timing_budget_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranging_timing_budget_encoder - ToF ranging timing budget encoder
// Turns a timing budget and inter-measurement period into the range-config
// A/B exponent:mantissa words and the inter-measurement register value.
// ----------------------------------------------------------------------------
//
//  channel   ports                          transfer when
//  -------   -----------------------------  ----------------------------
//  request   start, busy, req_data          start high, busy low
//  response  rsp_strobe, rsp_data           rsp_strobe high (one cycle)
//
// A bad budget, zero oscillator word or too short period is flagged in
// CHECK, a zero divisor in PREP; either goes straight to DONE. Otherwise the
// bit-serial divider sets the pace: macro period, word A and word B, then
// the inter-measurement value in autonomous mode only. Busy stays high
// until the strobe. Reset clears the sequencer, the strobe and the busy
// state of divider, multiplier and normalisers; the receiver cannot stall.
// ----------------------------------------------------------------------------
module ranging_timing_budget_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rtbe_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rtbe_pkg::rsp_type rsp_data
);

   localparam int unsigned BUS_W      = rtbe_pkg::BUS_W;
   localparam int unsigned DIVIDEND_W = rtbe_pkg::DIVIDEND_W;
   localparam int unsigned DIVISOR_W  = rtbe_pkg::DIVISOR_W;
   localparam int unsigned CNT_W      = rtbe_pkg::DIV_CNT_W;
   localparam int unsigned NUM_W      = rtbe_pkg::WORD_NUM_W;
   localparam int unsigned ALIGN      = rtbe_pkg::WORD_ALIGN;
   localparam int unsigned MCAND_W    = rtbe_pkg::MCAND_W;
   localparam int unsigned MPLIER_W   = rtbe_pkg::MPLIER_W;
   localparam int unsigned NORM_W     = rtbe_pkg::NORM_IN_W;
   localparam int unsigned MANT_W     = rtbe_pkg::MANT_W;
   localparam int unsigned EXP_W      = rtbe_pkg::EXP_W;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_CHECK     = 9'b000000010,
      S_DIV_MACRO = 9'b000000100,
      S_PREP      = 9'b000001000,
      S_DIV_A     = 9'b000010000,
      S_DIV_B     = 9'b000100000,
      S_DIV_IMV   = 9'b001000000,
      S_WAIT_NORM = 9'b010000000,
      S_DONE      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   rtbe_pkg::req_type   req_ff;
   rtbe_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]          status_ff, status_in;
   logic                auto_ff, auto_in;
   logic [BUS_W-1:0]    bus_ff, bus_in;
   logic [DIVISOR_W-1:0] macro_ff, macro_in;   // divisor for word A
   logic [DIVISOR_W-1:0] div_b_ff, div_b_in;
   logic [31:0]         imv_ff, imv_in;

   // combinational helpers
   logic                accept;
   logic [BUS_W-1:0]    bus_raw;
   logic                budget_bad;
   logic                period_bad;
   logic [DIVISOR_W-1:0] m_nine;
   logic [DIVISOR_W+1:0] m_three;
   logic [DIVISOR_W-1:0] div_b_calc;
   logic [NUM_W-1:0]    scaled;
   logic [NUM_W-1:0]    num_a;
   logic [NUM_W-1:0]    num_b;

   // divider hookup
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [CNT_W-1:0]      div_iters;
   logic                  div_busy;
   logic [DIVIDEND_W-1:0] div_quotient;

   // multiplier hookup
   logic                        mul_start;
   logic [MCAND_W-1:0]          mul_mcand;
   logic                        mul_busy;
   logic [MCAND_W+MPLIER_W-1:0] mul_product;

   // normalisers
   logic              norm_a_start, norm_b_start;
   logic [NORM_W-1:0] norm_a_value, norm_b_value;
   logic              norm_a_busy, norm_b_busy;
   logic [EXP_W-1:0]  exp_a, exp_b;
   logic [MANT_W-1:0] mant_a, mant_b;

   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // budget in us; continuous and autonomous offsets applied in CHECK
   assign bus_raw    = BUS_W'(req_ff.timing_budget_ms) * BUS_W'(rtbe_pkg::US_PER_MS);
   assign budget_bad = (req_ff.timing_budget_ms < 8'(rtbe_pkg::BUDGET_MIN_MS)) ||
                       (req_ff.timing_budget_ms > 8'(rtbe_pkg::BUDGET_MAX_MS));
   assign period_bad = (req_ff.inter_measurement_ms != '0) &&
                       (req_ff.inter_measurement_ms <= {8'd0, req_ff.timing_budget_ms});

   // macro period: 2304 * q wraps at 32 bits and >> 6, then x16 >> 6 leaves
   // the divisor for word A as (9 * q) mod 2^24; word B's is 3/4 of that
   assign m_nine     = div_quotient[DIVISOR_W-1:0] + {div_quotient[DIVISOR_W-4:0], 3'b000};
   assign m_three    = {2'b00, macro_ff} + {1'b0, macro_ff, 1'b0};
   assign div_b_calc = m_three[DIVISOR_W+1:2];

   // budget << 12 plus half the divisor for rounding
   assign scaled = NUM_W'({bus_ff, 12'd0});
   assign num_a  = scaled + NUM_W'(macro_ff >> 1);
   assign num_b  = scaled + NUM_W'(div_b_ff >> 1);

   assign mul_mcand = MCAND_W'(req_ff.inter_measurement_ms) * MCAND_W'(rtbe_pkg::IMV_NUMER);

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      auto_in       = auto_ff;
      bus_in        = bus_ff;
      macro_in      = macro_ff;
      div_b_in      = div_b_ff;
      imv_in        = imv_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      div_iters     = '0;
      mul_start     = 1'b0;
      norm_a_start  = 1'b0;
      norm_b_start  = 1'b0;
      norm_a_value  = div_quotient[NORM_W-1:0] - 1'b1;
      norm_b_value  = div_quotient[NORM_W-1:0] - 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            imv_in  = '0;
            auto_in = (req_ff.inter_measurement_ms != '0);
            if (budget_bad) begin
               status_in = rtbe_pkg::ST_BUDGET;
               state_in  = S_DONE;
            end else if (req_ff.osc_frequency == '0) begin
               status_in = rtbe_pkg::ST_OSC;
               state_in  = S_DONE;
            end else if (period_bad) begin
               status_in = rtbe_pkg::ST_PERIOD;
               state_in  = S_DONE;
            end else begin
               status_in = rtbe_pkg::ST_OK;
               if (req_ff.inter_measurement_ms == '0) begin
                  bus_in = bus_raw - BUS_W'(rtbe_pkg::CONT_OFFSET_US);
               end else begin
                  bus_in = (bus_raw - BUS_W'(rtbe_pkg::AUTO_OFFSET_US)) >> 1;
               end
               // 2^30 / osc
               div_start    = 1'b1;
               div_dividend = {1'b1, {(DIVIDEND_W-1){1'b0}}};
               div_divisor  = DIVISOR_W'(req_ff.osc_frequency);
               div_iters    = CNT_W'(NUM_W);
               // period * 211 * pll runs alongside
               mul_start    = 1'b1;
               state_in     = S_DIV_MACRO;
            end
         end

         S_DIV_MACRO: begin
            if (!div_busy) begin
               macro_in = m_nine;
               state_in = S_PREP;
            end
         end

         S_PREP: begin
            div_b_in = div_b_calc;
            if ((macro_ff == '0) || (div_b_calc == '0)) begin
               status_in = rtbe_pkg::ST_DIVZERO;
               state_in  = S_DONE;
            end else begin
               div_start    = 1'b1;
               div_dividend = {num_a, {ALIGN{1'b0}}};
               div_divisor  = macro_ff;
               div_iters    = CNT_W'(NUM_W);
               state_in     = S_DIV_A;
            end
         end

         S_DIV_A: begin
            if (!div_busy) begin
               norm_a_start = 1'b1;
               div_start    = 1'b1;
               div_dividend = {num_b, {ALIGN{1'b0}}};
               div_divisor  = div_b_ff;
               div_iters    = CNT_W'(NUM_W);
               state_in     = S_DIV_B;
            end
         end

         S_DIV_B: begin
            if (!div_busy && !(auto_ff && mul_busy)) begin
               norm_b_start = 1'b1;
               if (auto_ff) begin
                  div_start    = 1'b1;
                  div_dividend = mul_product;
                  div_divisor  = DIVISOR_W'(rtbe_pkg::IMV_DENOM);
                  div_iters    = CNT_W'(DIVIDEND_W);
                  state_in     = S_DIV_IMV;
               end else begin
                  state_in = S_WAIT_NORM;
               end
            end
         end

         S_DIV_IMV: begin
            if (!div_busy) begin
               imv_in   = div_quotient[31:0];
               state_in = S_WAIT_NORM;
            end
         end

         S_WAIT_NORM: begin
            if (!norm_a_busy && !norm_b_busy) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = status_ff;
            if (status_ff == rtbe_pkg::ST_OK) begin
               rsp_in.cfg_word_a             = {3'b000, exp_a, mant_a};
               rsp_in.cfg_word_b             = {3'b000, exp_b, mant_b};
               rsp_in.intermeasurement_value = imv_ff;
            end else begin
               rsp_in.cfg_word_a             = '0;
               rsp_in.cfg_word_b             = '0;
               rsp_in.intermeasurement_value = '0;
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
      auto_ff   <= auto_in;
      bus_ff    <= bus_in;
      macro_ff  <= macro_in;
      div_b_ff  <= div_b_in;
      imv_ff    <= imv_in;
   end

   rtbe_serial_div #(
      .DIVIDEND_W (DIVIDEND_W),
      .DIVISOR_W  (DIVISOR_W),
      .CNT_W      (CNT_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .iterations (div_iters),
      .busy       (div_busy),
      .quotient   (div_quotient)
   );

   rtbe_serial_mul #(
      .MCAND_W      (MCAND_W),
      .MPLIER_W     (MPLIER_W)
   ) u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_mcand),
      .multiplier   (req_ff.clock_pll),
      .busy         (mul_busy),
      .product      (mul_product)
   );

   rtbe_normalise #(
      .IN_W     (NORM_W),
      .MANT_W   (MANT_W),
      .EXP_W    (EXP_W)
   ) u_norm_a (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_a_start),
      .value    (norm_a_value),
      .busy     (norm_a_busy),
      .exponent (exp_a),
      .mantissa (mant_a)
   );

   rtbe_normalise #(
      .IN_W     (NORM_W),
      .MANT_W   (MANT_W),
      .EXP_W    (EXP_W)
   ) u_norm_b (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_b_start),
      .value    (norm_b_value),
      .busy     (norm_b_busy),
      .exponent (exp_b),
      .mantissa (mant_b)
   );

endmodule
